FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge once reset has been released.
`define ASSERT_SYNC(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/ssfc_pkg.sv
package ssfc_pkg;

  localparam logic [2:0] CMD_CONTROL     = 3'd0;
  localparam logic [2:0] CMD_TICK        = 3'd1;
  localparam logic [2:0] CMD_SERVO_SWEEP = 3'd2;
  localparam logic [2:0] CMD_ESC_SWEEP   = 3'd3;
  localparam logic [2:0] CMD_BEGIN       = 3'd4;
  localparam logic [2:0] CMD_RECLAMP     = 3'd5;

  localparam logic [1:0] SWEEP_NONE  = 2'd0;
  localparam logic [1:0] SWEEP_SERVO = 2'd1;
  localparam logic [1:0] SWEEP_ESC   = 2'd2;

  localparam logic [2:0] REG_STEERING_MIN     = 3'd0;
  localparam logic [2:0] REG_STEERING_MAX     = 3'd1;
  localparam logic [2:0] REG_STEERING_NEUTRAL = 3'd2;
  localparam logic [2:0] REG_THROTTLE_MIN     = 3'd3;
  localparam logic [2:0] REG_THROTTLE_MAX     = 3'd4;
  localparam logic [2:0] REG_THROTTLE_NEUTRAL = 3'd5;
  localparam logic [2:0] REG_STEERING_SLEW    = 3'd6;
  localparam logic [2:0] REG_THROTTLE_SLEW    = 3'd7;

  localparam logic [2:0] SRV_TO_MIN = 3'd0;
  localparam logic [2:0] SRV_TO_MAX = 3'd1;
  localparam logic [2:0] SRV_TO_NEU = 3'd2;

  localparam logic [2:0] ESC_DOWN      = 3'd0;
  localparam logic [2:0] ESC_DWELL_LO  = 3'd1;
  localparam logic [2:0] ESC_BACK      = 3'd2;
  localparam logic [2:0] ESC_DWELL_MID = 3'd3;
  localparam logic [2:0] ESC_UP        = 3'd4;
  localparam logic [2:0] ESC_HOME      = 3'd5;

  localparam logic [15:0] FAILSAFE_TIMEOUT_MS = 16'd500;
  localparam logic [4:0]  APPLY_INTERVAL_MS   = 5'd20;
  localparam logic [8:0]  SWEEP_DWELL_MS      = 9'd300;
  localparam logic [8:0]  SWEEP_INTERVAL_MS   = 9'd20;
  localparam logic [7:0]  SWEEP_STEP          = 8'd5;
  localparam logic signed [9:0] ESC_OFFSET    = 10'sd20;

  localparam logic [15:0] CTRL_AGE_MAX  = 16'hFFFF;
  localparam logic [4:0]  APPLY_AGE_MAX = 5'd31;
  localparam logic [8:0]  SWEEP_AGE_MAX = 9'd511;

  localparam logic [7:0] POS_RESET = 8'd90;

  typedef struct packed {
    logic [7:0] steering_min;
    logic [7:0] steering_max;
    logic [7:0] steering_neutral;
    logic [7:0] throttle_min;
    logic [7:0] throttle_max;
    logic [7:0] throttle_neutral;
    logic [7:0] steering_slew;
    logic [7:0] throttle_slew;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    steering_min:     8'd0,
    steering_max:     8'd180,
    steering_neutral: 8'd90,
    throttle_min:     8'd0,
    throttle_max:     8'd180,
    throttle_neutral: 8'd90,
    steering_slew:    8'd5,
    throttle_slew:    8'd5
  };

  typedef struct packed {
    logic [7:0] steering_drive;
    logic [7:0] throttle_drive;
    logic [7:0] steering_goal;
    logic [7:0] throttle_goal;
    logic       failsafe_on;
    logic [1:0] sweep_kind;
  } result_t;

endpackage

FILE: design/ssfc_if.sv
interface ssfc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] steer_request;
  logic [7:0] throttle_request;

  modport source (output valid, output command, output steer_request,
                  output throttle_request, input ready);
  modport sink (input valid, input command, input steer_request,
                input throttle_request, output ready);
endinterface

interface ssfc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] steering_drive;
  logic [7:0] throttle_drive;
  logic [7:0] steering_goal;
  logic [7:0] throttle_goal;
  logic       failsafe_on;
  logic [1:0] sweep_kind;

  modport source (output valid, output steering_drive, output throttle_drive,
                  output steering_goal, output throttle_goal, output failsafe_on,
                  output sweep_kind, input ready);
  modport sink (input valid, input steering_drive, input throttle_drive,
                input steering_goal, input throttle_goal, input failsafe_on,
                input sweep_kind, output ready);
endinterface

interface ssfc_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/ssfc_cfg.sv
module ssfc_cfg (
  input  logic                clk,
  input  logic                rst_n,
  ssfc_cfg_if.sink            cfg_bus,
  output ssfc_pkg::cfg_regs_t cfg
);

  ssfc_pkg::cfg_regs_t cfg_r;

  assign cfg_bus.ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= ssfc_pkg::CFG_RESET;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        ssfc_pkg::REG_STEERING_MIN:     cfg_r.steering_min     <= cfg_bus.data;
        ssfc_pkg::REG_STEERING_MAX:     cfg_r.steering_max     <= cfg_bus.data;
        ssfc_pkg::REG_STEERING_NEUTRAL: cfg_r.steering_neutral <= cfg_bus.data;
        ssfc_pkg::REG_THROTTLE_MIN:     cfg_r.throttle_min     <= cfg_bus.data;
        ssfc_pkg::REG_THROTTLE_MAX:     cfg_r.throttle_max     <= cfg_bus.data;
        ssfc_pkg::REG_THROTTLE_NEUTRAL: cfg_r.throttle_neutral <= cfg_bus.data;
        ssfc_pkg::REG_STEERING_SLEW:    cfg_r.steering_slew    <= cfg_bus.data;
        ssfc_pkg::REG_THROTTLE_SLEW:    cfg_r.throttle_slew    <= cfg_bus.data;
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: design/ssfc_core.sv
module ssfc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [2:0]          command,
  input  logic [7:0]          steer_request,
  input  logic [7:0]          throttle_request,
  input  ssfc_pkg::cfg_regs_t cfg,
  output ssfc_pkg::result_t   res
);

  function automatic logic [7:0] clamp_val(input logic signed [9:0] x,
                                           input logic [7:0] lo,
                                           input logic [7:0] hi);
    logic [7:0] r;
    if (x < $signed({2'b00, lo})) begin
      r = lo;
    end else if (x > $signed({2'b00, hi})) begin
      r = hi;
    end else begin
      r = x[7:0];
    end
    return r;
  endfunction

  function automatic logic [7:0] slew_val(input logic [7:0] cur,
                                          input logic [7:0] des,
                                          input logic [7:0] step);
    logic [7:0] d;
    logic [7:0] r;
    if (des >= cur) begin
      d = des - cur;
      r = (d <= step) ? des : cur + step;
    end else begin
      d = cur - des;
      r = (d <= step) ? des : cur - step;
    end
    return r;
  endfunction

  logic [7:0]  st_now_r, st_now_nxt;
  logic [7:0]  th_now_r, th_now_nxt;
  logic [7:0]  st_tgt_r, st_tgt_nxt;
  logic [7:0]  th_tgt_r, th_tgt_nxt;
  logic        failsafe_r, failsafe_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  sweep_val_r, sweep_val_nxt;
  logic [15:0] ctrl_age_r, ctrl_age_nxt;
  logic [4:0]  apply_age_r, apply_age_nxt;
  logic [8:0]  sweep_age_r, sweep_age_nxt;

  logic [15:0] ctrl_age_inc;
  logic [4:0]  apply_age_inc;
  logic [8:0]  sweep_age_inc;
  logic signed [9:0] th_neu_ext;
  logic [7:0]  esc_lo_goal;
  logic [7:0]  esc_hi_goal;
  logic [7:0]  servo_goal;
  logic [7:0]  esc_goal;
  logic        servo_phase_ok;
  logic        esc_phase_ok;
  logic [7:0]  servo_slewed;
  logic [7:0]  esc_slewed;
  logic        fs_trip;
  logic [7:0]  st_tgt_tick;
  logic [7:0]  th_tgt_tick;
  logic [7:0]  st_now_slewed;
  logic [7:0]  th_now_slewed;

  assign ctrl_age_inc  = (ctrl_age_r == ssfc_pkg::CTRL_AGE_MAX) ?
                         ctrl_age_r : ctrl_age_r + 16'd1;
  assign apply_age_inc = (apply_age_r == ssfc_pkg::APPLY_AGE_MAX) ?
                         apply_age_r : apply_age_r + 5'd1;
  assign sweep_age_inc = (sweep_age_r == ssfc_pkg::SWEEP_AGE_MAX) ?
                         sweep_age_r : sweep_age_r + 9'd1;

  assign th_neu_ext  = $signed({2'b00, cfg.throttle_neutral});
  assign esc_lo_goal = clamp_val(th_neu_ext - ssfc_pkg::ESC_OFFSET,
                                 cfg.throttle_min, cfg.throttle_max);
  assign esc_hi_goal = clamp_val(th_neu_ext + ssfc_pkg::ESC_OFFSET,
                                 cfg.throttle_min, cfg.throttle_max);

  always_comb begin
    case (phase_r)
      ssfc_pkg::SRV_TO_MIN: servo_goal = cfg.steering_min;
      ssfc_pkg::SRV_TO_MAX: servo_goal = cfg.steering_max;
      default:              servo_goal = cfg.steering_neutral;
    endcase
    case (phase_r)
      ssfc_pkg::ESC_DOWN: esc_goal = esc_lo_goal;
      ssfc_pkg::ESC_UP:   esc_goal = esc_hi_goal;
      default:            esc_goal = cfg.throttle_neutral;
    endcase
  end

  assign servo_phase_ok = (phase_r == ssfc_pkg::SRV_TO_MIN) ||
                          (phase_r == ssfc_pkg::SRV_TO_MAX) ||
                          (phase_r == ssfc_pkg::SRV_TO_NEU);
  assign esc_phase_ok   = (phase_r == ssfc_pkg::ESC_DOWN) ||
                          (phase_r == ssfc_pkg::ESC_BACK) ||
                          (phase_r == ssfc_pkg::ESC_UP)   ||
                          (phase_r == ssfc_pkg::ESC_HOME);

  assign servo_slewed = slew_val(sweep_val_r, servo_goal, ssfc_pkg::SWEEP_STEP);
  assign esc_slewed   = slew_val(sweep_val_r, esc_goal, ssfc_pkg::SWEEP_STEP);

  assign fs_trip       = ctrl_age_inc > ssfc_pkg::FAILSAFE_TIMEOUT_MS;
  assign st_tgt_tick   = fs_trip ? cfg.steering_neutral : st_tgt_r;
  assign th_tgt_tick   = fs_trip ? cfg.throttle_neutral : th_tgt_r;
  assign st_now_slewed = slew_val(st_now_r, st_tgt_tick, cfg.steering_slew);
  assign th_now_slewed = slew_val(th_now_r, th_tgt_tick, cfg.throttle_slew);

  always_comb begin
    st_now_nxt    = st_now_r;
    th_now_nxt    = th_now_r;
    st_tgt_nxt    = st_tgt_r;
    th_tgt_nxt    = th_tgt_r;
    failsafe_nxt  = failsafe_r;
    mode_nxt      = mode_r;
    phase_nxt     = phase_r;
    sweep_val_nxt = sweep_val_r;
    ctrl_age_nxt  = ctrl_age_r;
    apply_age_nxt = apply_age_r;
    sweep_age_nxt = sweep_age_r;
    if (accept) begin
      unique case (command)
        ssfc_pkg::CMD_CONTROL: begin
          mode_nxt     = ssfc_pkg::SWEEP_NONE;
          st_tgt_nxt   = clamp_val($signed({2'b00, steer_request}),
                                   cfg.steering_min, cfg.steering_max);
          th_tgt_nxt   = clamp_val($signed({2'b00, throttle_request}),
                                   cfg.throttle_min, cfg.throttle_max);
          ctrl_age_nxt = '0;
          failsafe_nxt = 1'b0;
        end
        ssfc_pkg::CMD_TICK: begin
          ctrl_age_nxt  = ctrl_age_inc;
          apply_age_nxt = apply_age_inc;
          sweep_age_nxt = sweep_age_inc;
          if (mode_r == ssfc_pkg::SWEEP_SERVO) begin
            if (sweep_age_inc >= ssfc_pkg::SWEEP_INTERVAL_MS) begin
              sweep_age_nxt = '0;
              if (!servo_phase_ok) begin
                mode_nxt = ssfc_pkg::SWEEP_NONE;
              end else begin
                sweep_val_nxt = servo_slewed;
                if (servo_slewed == servo_goal) begin
                  phase_nxt = phase_r + 3'd1;
                  if (phase_r == ssfc_pkg::SRV_TO_NEU) begin
                    mode_nxt = ssfc_pkg::SWEEP_NONE;
                  end
                end
              end
            end
          end else if (mode_r == ssfc_pkg::SWEEP_ESC) begin
            if (phase_r == ssfc_pkg::ESC_DWELL_LO || phase_r == ssfc_pkg::ESC_DWELL_MID) begin
              if (sweep_age_inc >= ssfc_pkg::SWEEP_DWELL_MS) begin
                phase_nxt     = phase_r + 3'd1;
                sweep_age_nxt = '0;
              end
            end else if (sweep_age_inc >= ssfc_pkg::SWEEP_INTERVAL_MS) begin
              sweep_age_nxt = '0;
              if (!esc_phase_ok) begin
                mode_nxt = ssfc_pkg::SWEEP_NONE;
              end else begin
                sweep_val_nxt = esc_slewed;
                if (esc_slewed == esc_goal) begin
                  if (phase_r == ssfc_pkg::ESC_UP) begin
                    phase_nxt = ssfc_pkg::ESC_HOME;
                  end else if (phase_r == ssfc_pkg::ESC_HOME) begin
                    mode_nxt = ssfc_pkg::SWEEP_NONE;
                  end else begin
                    phase_nxt = phase_r + 3'd1;
                  end
                end
                if ((phase_r == ssfc_pkg::ESC_HOME ||
                     (phase_r == ssfc_pkg::ESC_UP && esc_slewed == esc_goal)) &&
                    esc_slewed == cfg.throttle_neutral) begin
                  mode_nxt = ssfc_pkg::SWEEP_NONE;
                end
              end
            end
          end else begin
            if (fs_trip) begin
              st_tgt_nxt   = cfg.steering_neutral;
              th_tgt_nxt   = cfg.throttle_neutral;
              failsafe_nxt = 1'b1;
            end
            if (apply_age_inc >= ssfc_pkg::APPLY_INTERVAL_MS) begin
              apply_age_nxt = '0;
              st_now_nxt    = st_now_slewed;
              th_now_nxt    = th_now_slewed;
            end
          end
        end
        ssfc_pkg::CMD_SERVO_SWEEP: begin
          mode_nxt      = ssfc_pkg::SWEEP_SERVO;
          phase_nxt     = ssfc_pkg::SRV_TO_MIN;
          sweep_age_nxt = ssfc_pkg::SWEEP_AGE_MAX;
          sweep_val_nxt = cfg.steering_neutral;
        end
        ssfc_pkg::CMD_ESC_SWEEP: begin
          mode_nxt      = ssfc_pkg::SWEEP_ESC;
          phase_nxt     = ssfc_pkg::ESC_DOWN;
          sweep_age_nxt = ssfc_pkg::SWEEP_AGE_MAX;
          sweep_val_nxt = cfg.throttle_neutral;
        end
        ssfc_pkg::CMD_BEGIN: begin
          st_now_nxt   = cfg.steering_neutral;
          th_now_nxt   = cfg.throttle_neutral;
          st_tgt_nxt   = cfg.steering_neutral;
          th_tgt_nxt   = cfg.throttle_neutral;
          ctrl_age_nxt = '0;
        end
        ssfc_pkg::CMD_RECLAMP: begin
          st_tgt_nxt = clamp_val($signed({2'b00, st_tgt_r}),
                                 cfg.steering_min, cfg.steering_max);
          th_tgt_nxt = clamp_val($signed({2'b00, th_tgt_r}),
                                 cfg.throttle_min, cfg.throttle_max);
          st_now_nxt = clamp_val($signed({2'b00, st_now_r}),
                                 cfg.steering_min, cfg.steering_max);
          th_now_nxt = clamp_val($signed({2'b00, th_now_r}),
                                 cfg.throttle_min, cfg.throttle_max);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_now_r    <= ssfc_pkg::POS_RESET;
      th_now_r    <= ssfc_pkg::POS_RESET;
      st_tgt_r    <= ssfc_pkg::POS_RESET;
      th_tgt_r    <= ssfc_pkg::POS_RESET;
      failsafe_r  <= 1'b0;
      mode_r      <= ssfc_pkg::SWEEP_NONE;
      phase_r     <= '0;
      sweep_val_r <= ssfc_pkg::POS_RESET;
      ctrl_age_r  <= '0;
      apply_age_r <= '0;
      sweep_age_r <= ssfc_pkg::SWEEP_AGE_MAX;
    end else begin
      st_now_r    <= st_now_nxt;
      th_now_r    <= th_now_nxt;
      st_tgt_r    <= st_tgt_nxt;
      th_tgt_r    <= th_tgt_nxt;
      failsafe_r  <= failsafe_nxt;
      mode_r      <= mode_nxt;
      phase_r     <= phase_nxt;
      sweep_val_r <= sweep_val_nxt;
      ctrl_age_r  <= ctrl_age_nxt;
      apply_age_r <= apply_age_nxt;
      sweep_age_r <= sweep_age_nxt;
    end
  end

  assign res.steering_drive = (mode_nxt == ssfc_pkg::SWEEP_SERVO) ? sweep_val_nxt : st_now_nxt;
  assign res.throttle_drive = (mode_nxt == ssfc_pkg::SWEEP_ESC) ? sweep_val_nxt : th_now_nxt;
  assign res.steering_goal  = st_tgt_nxt;
  assign res.throttle_goal  = th_tgt_nxt;
  assign res.failsafe_on    = failsafe_nxt;
  assign res.sweep_kind     = mode_nxt;

endmodule

FILE: design/ssfc_out_buf.sv
module ssfc_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ssfc_pkg::result_t res,
  output logic              can_take,
  ssfc_out_if.source        out_bus
);

  ssfc_pkg::result_t main_r;
  ssfc_pkg::result_t skid_r;
  logic              main_valid_r;
  logic              skid_valid_r;
  logic              main_free;

  assign main_free = !main_valid_r || out_bus.ready;
  assign can_take  = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (main_free) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= push;
      end else begin
        main_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      if (skid_valid_r) begin
        main_r <= skid_r;
        if (push) begin
          skid_r <= res;
        end
      end else if (push) begin
        main_r <= res;
      end
    end else if (push) begin
      skid_r <= res;
    end
  end

  assign out_bus.valid          = main_valid_r;
  assign out_bus.steering_drive = main_r.steering_drive;
  assign out_bus.throttle_drive = main_r.throttle_drive;
  assign out_bus.steering_goal  = main_r.steering_goal;
  assign out_bus.throttle_goal  = main_r.throttle_goal;
  assign out_bus.failsafe_on    = main_r.failsafe_on;
  assign out_bus.sweep_kind     = main_r.sweep_kind;

endmodule

FILE: design/servo_slew_failsafe_controller_top.sv
// Steering and throttle servo controller with slew limiting, a control timeout failsafe and
// two test sweeps. Every accepted command beat yields exactly one result beat that shows the
// state after the command. Commands are taken at one per clock: the whole update is computed in
// the cycle the command beat is accepted and registered into the output stage at that edge. A
// two-entry output stage lets one further command in while a result waits; the input stalls
// only when both entries are held. Configuration writes are accepted in every cycle and take
// effect for the next command; write them only while no command is in flight.
`include "assert_macros.svh"

module servo_slew_failsafe_controller_top (
  input  logic       clk,
  input  logic       rst_n,
  ssfc_in_if.sink    in_bus,
  ssfc_out_if.source out_bus,
  ssfc_cfg_if.sink   cfg_bus
);

  ssfc_pkg::cfg_regs_t cfg;
  ssfc_pkg::result_t   res;
  logic                can_take;
  logic                accept;

  assign in_bus.ready = can_take;
  assign accept       = in_bus.valid && can_take;

  ssfc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .cfg     (cfg)
  );

  ssfc_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (accept),
    .command          (in_bus.command),
    .steer_request    (in_bus.steer_request),
    .throttle_request (in_bus.throttle_request),
    .cfg              (cfg),
    .res              (res)
  );

  ssfc_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .res      (res),
    .can_take (can_take),
    .out_bus  (out_bus)
  );

  `ASSERT_SYNC(a_stall_means_full, !in_bus.ready |-> out_bus.valid, "input stalled with empty output")
  `ASSERT_SYNC(a_beat_shows_up, accept |=> out_bus.valid, "accepted beat produced no result")
  `ASSERT_SYNC(a_skid_fills, (accept && out_bus.valid && !out_bus.ready) |=> !in_bus.ready, "skid entry not taken")

endmodule

FILE: verif/tb_servo_slew_failsafe_controller_top.sv
`timescale 1ns / 100ps

module tb_servo_slew_failsafe_controller_top;
  import ssfc_pkg::*;

  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4;

  logic clk = 1'b0;
  logic rst_n;

  ssfc_in_if  in_if();
  ssfc_out_if out_if();
  ssfc_cfg_if cfg_if();

  servo_slew_failsafe_controller_top DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if),
    .cfg_bus (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the controller: settings, positions, targets and ages.
  cfg_regs_t    regs;
  logic [7:0]   steer_pos, throt_pos, steer_goal, throt_goal, sweep_pos;
  logic         failsafe_set;
  logic [1:0]   active_sweep;
  logic [2:0]   sweep_stage;
  logic [15:0]  control_ms;
  logic [4:0]   apply_ms;
  logic [8:0]   sweep_ms;

  result_t expected_results[$];
  int      mismatch_count = 0;
  int      beats_sent = 0;
  int      gap_pct = 0;
  int      stall_pct = 0;
  int      stall_left = 0;
  int      quiet_cycles = 0;

  function automatic logic [7:0] limit_to(int x, logic [7:0] lo, logic [7:0] hi);
    if (x < int'(lo)) return lo;
    if (x > int'(hi)) return hi;
    return 8'(x);
  endfunction

  function automatic logic [7:0] step_toward(logic [7:0] cur, logic [7:0] des, logic [7:0] step);
    int diff;
    int abs_diff;
    diff = int'(des) - int'(cur);
    abs_diff = diff < 0 ? -diff : diff;
    if (abs_diff <= int'(step)) return des;
    return diff > 0 ? cur + step : cur - step;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic advance_one_ms();
    logic [7:0] goal;
    if (control_ms != CTRL_AGE_MAX) control_ms++;
    if (apply_ms != APPLY_AGE_MAX) apply_ms++;
    if (sweep_ms != SWEEP_AGE_MAX) sweep_ms++;
    if (active_sweep == SWEEP_SERVO) begin
      if (sweep_ms >= SWEEP_INTERVAL_MS) begin
        sweep_ms = '0;
        if (sweep_stage > SRV_TO_NEU) begin
          active_sweep = SWEEP_NONE;
        end else begin
          case (sweep_stage)
            SRV_TO_MIN: goal = regs.steering_min;
            SRV_TO_MAX: goal = regs.steering_max;
            default:    goal = regs.steering_neutral;
          endcase
          sweep_pos = step_toward(sweep_pos, goal, SWEEP_STEP);
          if (sweep_pos == goal) begin
            sweep_stage++;
            if (sweep_stage > SRV_TO_NEU) active_sweep = SWEEP_NONE;
          end
        end
      end
    end else if (active_sweep == SWEEP_ESC) begin
      if (sweep_stage == ESC_DWELL_LO || sweep_stage == ESC_DWELL_MID) begin
        if (sweep_ms >= SWEEP_DWELL_MS) begin
          sweep_stage++;
          sweep_ms = '0;
        end
      end else if (sweep_ms >= SWEEP_INTERVAL_MS) begin
        sweep_ms = '0;
        if (sweep_stage > ESC_HOME) begin
          active_sweep = SWEEP_NONE;
        end else begin
          case (sweep_stage)
            ESC_DOWN: goal = limit_to(int'(regs.throttle_neutral) - int'(ESC_OFFSET),
                                      regs.throttle_min, regs.throttle_max);
            ESC_UP:   goal = limit_to(int'(regs.throttle_neutral) + int'(ESC_OFFSET),
                                      regs.throttle_min, regs.throttle_max);
            default:  goal = regs.throttle_neutral;
          endcase
          sweep_pos = step_toward(sweep_pos, goal, SWEEP_STEP);
          if (sweep_pos == goal) begin
            if (sweep_stage == ESC_DOWN || sweep_stage == ESC_BACK) sweep_stage++;
            else if (sweep_stage == ESC_UP) sweep_stage = ESC_HOME;
            else active_sweep = SWEEP_NONE;
          end
          if (sweep_stage == ESC_HOME && sweep_pos == regs.throttle_neutral) begin
            active_sweep = SWEEP_NONE;
          end
        end
      end
    end else begin
      if (control_ms > FAILSAFE_TIMEOUT_MS) begin
        steer_goal   = regs.steering_neutral;
        throt_goal   = regs.throttle_neutral;
        failsafe_set = 1'b1;
      end
      if (apply_ms >= APPLY_INTERVAL_MS) begin
        apply_ms  = '0;
        steer_pos = step_toward(steer_pos, steer_goal, regs.steering_slew);
        throt_pos = step_toward(throt_pos, throt_goal, regs.throttle_slew);
      end
    end
  endtask

  task automatic apply_command(input logic [2:0] cmd, input logic [7:0] steer_req,
                               input logic [7:0] throt_req, output result_t res);
    case (cmd)
      CMD_CONTROL: begin
        active_sweep = SWEEP_NONE;
        steer_goal   = limit_to(int'(steer_req), regs.steering_min, regs.steering_max);
        throt_goal   = limit_to(int'(throt_req), regs.throttle_min, regs.throttle_max);
        control_ms   = '0;
        failsafe_set = 1'b0;
      end
      CMD_TICK: advance_one_ms();
      CMD_SERVO_SWEEP: begin
        active_sweep = SWEEP_SERVO;
        sweep_stage  = SRV_TO_MIN;
        sweep_ms     = SWEEP_AGE_MAX;
        sweep_pos    = regs.steering_neutral;
      end
      CMD_ESC_SWEEP: begin
        active_sweep = SWEEP_ESC;
        sweep_stage  = ESC_DOWN;
        sweep_ms     = SWEEP_AGE_MAX;
        sweep_pos    = regs.throttle_neutral;
      end
      CMD_BEGIN: begin
        steer_pos  = regs.steering_neutral;
        throt_pos  = regs.throttle_neutral;
        steer_goal = steer_pos;
        throt_goal = throt_pos;
        control_ms = '0;
      end
      CMD_RECLAMP: begin
        steer_goal = limit_to(int'(steer_goal), regs.steering_min, regs.steering_max);
        throt_goal = limit_to(int'(throt_goal), regs.throttle_min, regs.throttle_max);
        steer_pos  = limit_to(int'(steer_pos), regs.steering_min, regs.steering_max);
        throt_pos  = limit_to(int'(throt_pos), regs.throttle_min, regs.throttle_max);
      end
      default: ;
    endcase
    res.steering_drive = (active_sweep == SWEEP_SERVO) ? sweep_pos : steer_pos;
    res.throttle_drive = (active_sweep == SWEEP_ESC) ? sweep_pos : throt_pos;
    res.steering_goal  = steer_goal;
    res.throttle_goal  = throt_goal;
    res.failsafe_on    = failsafe_set;
    res.sweep_kind     = active_sweep;
  endtask

  task automatic send_command(input logic [2:0] cmd, input logic [7:0] steer_req,
                              input logic [7:0] throt_req);
    result_t res;
    @(negedge clk);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_if.valid            <= 1'b1;
    in_if.command          <= cmd;
    in_if.steer_request    <= steer_req;
    in_if.throttle_request <= throt_req;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    apply_command(cmd, steer_req, throt_req, res);
    expected_results.push_back(res);
    beats_sent++;
  endtask

  task automatic send_tick();
    send_command(CMD_TICK, rand_byte(), rand_byte());
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    case (idx)
      REG_STEERING_MIN:     regs.steering_min     = value;
      REG_STEERING_MAX:     regs.steering_max     = value;
      REG_STEERING_NEUTRAL: regs.steering_neutral = value;
      REG_THROTTLE_MIN:     regs.throttle_min     = value;
      REG_THROTTLE_MAX:     regs.throttle_max     = value;
      REG_THROTTLE_NEUTRAL: regs.throttle_neutral = value;
      REG_STEERING_SLEW:    regs.steering_slew    = value;
      default:              regs.throttle_slew    = value;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic write_all_regs(input cfg_regs_t v);
    write_reg(REG_STEERING_MIN, v.steering_min);
    write_reg(REG_STEERING_MAX, v.steering_max);
    write_reg(REG_STEERING_NEUTRAL, v.steering_neutral);
    write_reg(REG_THROTTLE_MIN, v.throttle_min);
    write_reg(REG_THROTTLE_MAX, v.throttle_max);
    write_reg(REG_THROTTLE_NEUTRAL, v.throttle_neutral);
    write_reg(REG_STEERING_SLEW, v.steering_slew);
    write_reg(REG_THROTTLE_SLEW, v.throttle_slew);
  endtask

  task automatic set_idling(input bit on);
    gap_pct   = on ? 12 : 0;
    stall_pct = on ? 5 : 0;
    if (!on) stall_left = 0;
  endtask

  function automatic logic [7:0] pick_request();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd180;
      3:       return 8'd181;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_setting();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd180;
      default: return 8'($urandom_range(0, 180));
    endcase
  endfunction

  task automatic run_random_episode(input bit with_idling);
    if (with_idling) set_idling($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 4))
      0: begin
        send_command(CMD_CONTROL, pick_request(), pick_request());
        repeat ($urandom_range(5, 40)) begin
          if ($urandom_range(0, 19) == 0) begin
            send_command(3'($urandom_range(CMD_BEGIN, CMD_SPARE_7)), rand_byte(), rand_byte());
          end else begin
            send_tick();
          end
        end
      end
      1: begin
        repeat ($urandom_range(1, 8)) begin
          send_command(3'($urandom_range(0, 7)), rand_byte(), rand_byte());
        end
      end
      2: begin
        send_command($urandom_range(0, 1) ? CMD_SERVO_SWEEP : CMD_ESC_SWEEP,
                     rand_byte(), rand_byte());
        repeat ($urandom_range(10, 120)) send_tick();
        if ($urandom_range(0, 1)) send_command(CMD_CONTROL, pick_request(), pick_request());
      end
      3: begin
        send_command($urandom_range(0, 1) ? CMD_BEGIN : CMD_RECLAMP, rand_byte(),
                     rand_byte());
        repeat ($urandom_range(1, 30)) send_tick();
      end
      default: repeat ($urandom_range(20, 80)) send_tick();
    endcase
  endtask

  task automatic test_directed_commands();
    send_tick();
    send_command(CMD_CONTROL, 8'd0, 8'd0);
    send_command(CMD_CONTROL, 8'd255, 8'd255);
    send_command(CMD_CONTROL, 8'd180, 8'd181);
    send_command(CMD_BEGIN, 8'd0, 8'd0);
    send_command(CMD_RECLAMP, 8'd255, 8'd255);
    send_command(CMD_SPARE_6, 8'hA5, 8'h5A);
    send_command(CMD_SPARE_7, 8'hFF, 8'hFF);
    send_command(CMD_SERVO_SWEEP, 8'd0, 8'd0);
    send_tick();
    send_command(CMD_BEGIN, 8'd0, 8'd0);
    send_command(CMD_RECLAMP, 8'd0, 8'd0);
    send_tick();
    send_command(CMD_CONTROL, 8'd45, 8'd135);
    send_command(CMD_ESC_SWEEP, 8'd0, 8'd0);
    send_tick();
    send_command(CMD_CONTROL, 8'd90, 8'd90);
    wait_all_results();
    // Minimum above maximum: a clamp picks the minimum for low values, else the maximum.
    write_reg(REG_STEERING_MIN, 8'd120);
    write_reg(REG_STEERING_MAX, 8'd60);
    write_reg(REG_THROTTLE_MIN, 8'd100);
    write_reg(REG_THROTTLE_MAX, 8'd20);
    send_command(CMD_CONTROL, 8'd0, 8'd0);
    send_command(CMD_CONTROL, 8'd200, 8'd200);
    send_command(CMD_CONTROL, 8'd90, 8'd50);
    send_command(CMD_RECLAMP, 8'd0, 8'd0);
    send_command(CMD_BEGIN, 8'd0, 8'd0);
    wait_all_results();
    write_all_regs(CFG_RESET);
  endtask

  task automatic test_failsafe_timeout();
    cfg_regs_t settings;
    settings = CFG_RESET;
    settings.steering_neutral = 8'd180;
    settings.throttle_neutral = 8'd0;
    settings.steering_slew    = 8'd180;
    settings.throttle_slew    = 8'd1;
    wait_all_results();
    write_all_regs(settings);
    set_idling(1'b1);
    send_command(CMD_CONTROL, pick_request(), pick_request());
    while (!failsafe_set) begin
      case ($urandom_range(0, 39))
        0:       send_command(CMD_RECLAMP, rand_byte(), rand_byte());
        1:       send_command(CMD_SPARE_6, rand_byte(), rand_byte());
        2:       send_command(CMD_SPARE_7, rand_byte(), rand_byte());
        default: send_tick();
      endcase
    end
    repeat (30) send_tick();
    send_command(CMD_CONTROL, pick_request(), pick_request());
    repeat (25) send_tick();
  endtask

  task automatic test_servo_sweep();
    cfg_regs_t settings;
    int neutral;
    int span;
    for (int run = 0; run < 3; run++) begin
      neutral  = $urandom_range(20, 160);
      span     = $urandom_range(3, 12);
      settings = CFG_RESET;
      settings.steering_neutral = 8'(neutral);
      case (run)
        0: begin
          settings.steering_min = 8'(neutral - span);
          settings.steering_max = 8'(neutral + span);
        end
        1: begin
          settings.steering_min = 8'(neutral + span);
          settings.steering_max = 8'(neutral - span);
        end
        default: begin
          settings.steering_min = 8'(neutral);
          settings.steering_max = 8'(neutral);
        end
      endcase
      wait_all_results();
      write_all_regs(settings);
      send_command(CMD_SERVO_SWEEP, rand_byte(), rand_byte());
      while (active_sweep != SWEEP_NONE) begin
        case ($urandom_range(0, 24))
          0:       send_command(CMD_BEGIN, rand_byte(), rand_byte());
          1:       send_command(CMD_RECLAMP, rand_byte(), rand_byte());
          2:       send_command(CMD_SPARE_6, rand_byte(), rand_byte());
          default: send_tick();
        endcase
      end
      repeat ($urandom_range(1, 25)) send_tick();
    end
    send_command(CMD_SERVO_SWEEP, 8'd0, 8'd0);
    repeat ($urandom_range(5, 60)) send_tick();
    send_command(CMD_CONTROL, pick_request(), pick_request());
  endtask

  task automatic test_esc_sweep();
    cfg_regs_t settings;
    int neutral;
    neutral  = $urandom_range(20, 160);
    settings = CFG_RESET;
    settings.throttle_neutral = 8'(neutral);
    settings.throttle_min     = 8'(neutral - $urandom_range(0, 10));
    settings.throttle_max     = 8'(neutral + $urandom_range(0, 10));
    wait_all_results();
    write_all_regs(settings);
    send_command(CMD_ESC_SWEEP, rand_byte(), rand_byte());
    while (active_sweep != SWEEP_NONE) begin
      case ($urandom_range(0, 49))
        0:       send_command(CMD_SPARE_6, rand_byte(), rand_byte());
        1:       send_command(CMD_RECLAMP, rand_byte(), rand_byte());
        2:       send_command(CMD_SPARE_7, rand_byte(), rand_byte());
        default: send_tick();
      endcase
    end
    // The sweep outlasts the control timeout, so the next plain tick trips the failsafe.
    while (!failsafe_set) send_tick();
    repeat (30) send_tick();
    send_command(CMD_CONTROL, pick_request(), pick_request());

    settings = CFG_RESET;
    settings.throttle_neutral = 8'd10;
    wait_all_results();
    write_all_regs(settings);
    send_command(CMD_ESC_SWEEP, 8'd0, 8'd0);
    while (sweep_stage != ESC_DWELL_LO) send_tick();
    repeat ($urandom_range(20, 80)) send_tick();
    send_command(CMD_CONTROL, pick_request(), pick_request());
  endtask

  task automatic test_random_traffic();
    cfg_regs_t settings;
    int first_beat;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: settings = '{steering_min: 8'd0, steering_max: 8'd180, steering_neutral: 8'd0,
                        throttle_min: 8'd0, throttle_max: 8'd180, throttle_neutral: 8'd180,
                        steering_slew: 8'd0, throttle_slew: 8'd180};
        1: settings = '{steering_min: 8'd180, steering_max: 8'd180, steering_neutral: 8'd180,
                        throttle_min: 8'd180, throttle_max: 8'd180, throttle_neutral: 8'd180,
                        steering_slew: 8'd180, throttle_slew: 8'd0};
        default: settings = '{steering_min: pick_setting(), steering_max: pick_setting(),
                              steering_neutral: pick_setting(), throttle_min: pick_setting(),
                              throttle_max: pick_setting(), throttle_neutral: pick_setting(),
                              steering_slew: pick_setting(), throttle_slew: pick_setting()};
      endcase
      wait_all_results();
      write_all_regs(settings);
      first_beat = beats_sent;
      while (beats_sent - first_beat < 50) run_random_episode(1'b1);
    end
  endtask

  task automatic test_unthrottled_tail();
    int first_beat;
    set_idling(1'b0);
    first_beat = beats_sent;
    while (beats_sent - first_beat < 90) run_random_episode(1'b0);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_if.ready <= 1'b0;
      stall_left = $urandom_range(1, 18) - 1;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual %0d %0d %0d %0d %0d %0d",
                 $time, out_if.steering_drive, out_if.throttle_drive, out_if.steering_goal,
                 out_if.throttle_goal, out_if.failsafe_on, out_if.sweep_kind);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("steering_drive", want.steering_drive, out_if.steering_drive);
        check_field("throttle_drive", want.throttle_drive, out_if.throttle_drive);
        check_field("steering_goal", want.steering_goal, out_if.steering_goal);
        check_field("throttle_goal", want.throttle_goal, out_if.throttle_goal);
        check_field("failsafe_on", 8'(want.failsafe_on), 8'(out_if.failsafe_on));
        check_field("sweep_kind", 8'(want.sweep_kind), 8'(out_if.sweep_kind));
      end
    end
  end

  // A run is declared hung when no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst_n                  = 1'b0;
    in_if.valid            = 1'b0;
    in_if.command          = CMD_CONTROL;
    in_if.steer_request    = 8'd0;
    in_if.throttle_request = 8'd0;
    out_if.ready           = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.index           = REG_STEERING_MIN;
    cfg_if.data            = 8'd0;

    regs         = CFG_RESET;
    steer_pos    = POS_RESET;
    throt_pos    = POS_RESET;
    steer_goal   = POS_RESET;
    throt_goal   = POS_RESET;
    sweep_pos    = POS_RESET;
    failsafe_set = 1'b0;
    active_sweep = SWEEP_NONE;
    sweep_stage  = SRV_TO_MIN;
    control_ms   = '0;
    apply_ms     = '0;
    sweep_ms     = SWEEP_AGE_MAX;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_commands();
    test_failsafe_timeout();
    test_servo_sweep();
    test_esc_sweep();
    test_random_traffic();
    test_unthrottled_tail();

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
